>>> hdl/rgbfb_pkg.sv
// Shared types, constants and the line encoding function for the RGB LED
// frame buffer encoder. No dependencies.
package rgbfb_pkg;

    // Number of pixels in the chain and the width of a row address.
    localparam int PIXELS = 16;
    localparam int ROW_W  = (PIXELS > 1) ? $clog2(PIXELS) : 1;

    // Request codes carried in the req_type field.
    typedef enum logic [2:0] {
        REQ_COLOR       = 3'd0,
        REQ_HUE         = 3'd1,
        REQ_CLEAR_PIXEL = 3'd2,
        REQ_CLEAR_ALL   = 3'd3,
        REQ_UPDATE      = 3'd4
    } t_req;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SEND
    } t_state;

    // Byte position within a pixel row.
    localparam logic [1:0] BYTE_FIRST = 2'd0;
    localparam logic [1:0] BYTE_LAST  = 2'd2;

    // Colour wheel constants.
    localparam logic [7:0] WHEEL_STEP_MAX = 8'd63;
    localparam logic [1:0] BRIGHT_MAX     = 2'd2;
    localparam logic [1:0] PHASE_UNUSED   = 2'd3;

    // One byte handed to the line output stage.
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } t_word_req;

    // Each pair of data bits becomes one SPI byte: nibble 0x6 for a one and
    // 0x4 for a zero, the most significant pair in the top byte.
    function automatic logic [31:0] encode_byte(input logic [7:0] data);
        logic [31:0] word;
        word = '0;
        for (int k = 0; k < 4; k++) begin
            word[31 - 8 * k -: 8] = {2'b01, data[7 - 2 * k], 1'b0,
                                     2'b01, data[6 - 2 * k], 1'b0};
        end
        return word;
    endfunction

endpackage

>>> hdl/rgb_led_frame_buffer_encoder.sv
// Top level of the RGB LED frame buffer encoder: pixel store, request
// sequencer and colour wheel. Depends on rgbfb_pkg and rgbfb_line_out.
//
//  Channel   Direction  Handshake                 Carries
//  --------  ---------  ------------------------  -------------------------------
//  request   in         i_in_valid / o_in_ready   req_type, pixel, RGB, hue, bright
//  line      out        o_out_valid / i_out_ready line_word, last_word
//  config    in         i_cfg_valid / o_cfg_ready colour order bit
//
// A colour write, hue write, pixel clear or unknown request is done in the
// accepting cycle. An update or clear-all walks the rows in order, and each
// pixel row takes a read on the single read port of the store (S_READ) and
// then the shared byte encoder (S_SEND), one colour byte at a time, waiting
// out any output stalls.
// Reset is synchronous and active low; it empties the output register, sets
// the colour order to green-red-blue and marks every pixel row as zero.
// While the line channel stalls the sequencer waits in place; the last word
// may still wait in the output register while the next request is taken.
module rgb_led_frame_buffer_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel.
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_req_type,
    input  logic [3:0]  i_pixel,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic [7:0]  i_hue,
    input  logic [1:0]  i_bright,
    // Line channel.
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_line_word,
    output logic        o_last_word,
    // Configuration channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data
);
    import rgbfb_pkg::*;

    // Pixel store: one 24-bit row per pixel, first stored byte on top. A row
    // whose valid bit is clear reads as zero, which gives the cleared store
    // after reset and after a clear-all without a sweep.
    logic [23:0]       mem [PIXELS];
    logic [PIXELS-1:0] r_row_ok;

    t_state            r_state, n_state;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [1:0]        r_byte, n_byte;
    logic              r_color_order;
    logic [23:0]       r_rd_data;
    logic              r_rd_ok;

    logic              accept;
    logic [7:0]        px_ext;
    logic              px_ok;
    logic [ROW_W-1:0]  wr_row;
    logic              wr_en;
    logic [23:0]       wr_data;
    logic              clr_row;
    logic              clr_all;

    // Colour wheel and byte ordering.
    logic [1:0]        shift;
    logic [7:0]        up;
    logic [7:0]        down;
    logic [7:0]        cr, cg, cb;
    logic              hue_ok;

    t_word_req         word_req;
    logic              line_free;
    logic [7:0]        sel_byte;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_order <= 1'b0;
        end else if (i_cfg_valid) begin
            r_color_order <= i_cfg_data;
        end
    end

    // Pixels beyond the chain are ignored.
    assign px_ext = {4'b0000, i_pixel};
    assign px_ok  = (px_ext < 8'(PIXELS));
    assign wr_row = px_ext[ROW_W-1:0];

    // Hue write: the low six bits ramp one channel up and another down, the
    // top two bits pick the phase. Brightness three behaves as two.
    assign shift = (i_bright > BRIGHT_MAX) ? BRIGHT_MAX : i_bright;
    assign up    = {2'b00, i_hue[5:0]} << shift;
    assign down  = (WHEEL_STEP_MAX << shift) - up;
    assign hue_ok = (i_hue[7:6] != PHASE_UNUSED);

    always_comb begin
        cr = i_red;
        cg = i_green;
        cb = i_blue;
        if (i_req_type == REQ_HUE) begin
            case (i_hue[7:6])
                2'd0:    begin cr = down; cg = up;   cb = 8'd0; end
                2'd1:    begin cr = 8'd0; cg = down; cb = up;   end
                default: begin cr = up;   cg = 8'd0; cb = down; end
            endcase
        end
    end

    assign wr_data = r_color_order ? {cr, cg, cb} : {cg, cr, cb};

    // Byte of the current row that goes to the encoder.
    always_comb begin
        case (r_byte)
            2'd0:    sel_byte = r_rd_data[23:16];
            2'd1:    sel_byte = r_rd_data[15:8];
            default: sel_byte = r_rd_data[7:0];
        endcase
        if (!r_rd_ok) begin
            sel_byte = 8'd0;
        end
    end

    // Sequencer: next state and the store controls.
    always_comb begin
        n_state  = r_state;
        n_row    = r_row;
        n_byte   = r_byte;
        wr_en    = 1'b0;
        clr_row  = 1'b0;
        clr_all  = 1'b0;
        word_req = '{valid: 1'b0, data: sel_byte, last: 1'b0};
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_req_type)
                        REQ_COLOR: begin
                            wr_en = px_ok;
                        end
                        REQ_HUE: begin
                            wr_en = px_ok && hue_ok;
                        end
                        REQ_CLEAR_PIXEL: begin
                            clr_row = px_ok;
                        end
                        REQ_CLEAR_ALL: begin
                            clr_all = 1'b1;
                            n_row   = '0;
                            n_state = S_READ;
                        end
                        REQ_UPDATE: begin
                            n_row   = '0;
                            n_state = S_READ;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                n_byte  = BYTE_FIRST;
                n_state = S_SEND;
            end
            S_SEND: begin
                if (line_free) begin
                    word_req.valid = 1'b1;
                    word_req.last  = (r_byte == BYTE_LAST) &&
                                     (r_row == ROW_W'(PIXELS - 1));
                    n_byte = r_byte + 2'd1;
                    if (r_byte == BYTE_LAST) begin
                        if (r_row == ROW_W'(PIXELS - 1)) begin
                            n_state = S_IDLE;
                        end else begin
                            n_row   = r_row + ROW_W'(1);
                            n_state = S_READ;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row  <= n_row;
        r_byte <= n_byte;
    end

    // Row valid bits: set by a write, cleared by reset and by the clears.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_ok <= '0;
        end else if (clr_all) begin
            r_row_ok <= '0;
        end else if (wr_en) begin
            r_row_ok[wr_row] <= 1'b1;
        end else if (clr_row) begin
            r_row_ok[wr_row] <= 1'b0;
        end
    end

    // Store write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_row] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_rd_data <= mem[r_row];
            r_rd_ok   <= r_row_ok[r_row];
        end
    end

    rgbfb_line_out u_line_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (word_req),
        .o_free      (line_free),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_line_word (o_line_word),
        .o_last_word (o_last_word)
    );

endmodule

>>> hdl/rgbfb_line_out.sv
// Line output stage: encodes one stored byte into a 32-bit SPI word and
// holds it in an output register until taken. Depends on rgbfb_pkg.
module rgbfb_line_out (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rgbfb_pkg::t_word_req i_req,
    output logic               o_free,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [31:0]        o_line_word,
    output logic               o_last_word
);
    import rgbfb_pkg::*;

    logic        r_valid;
    logic [31:0] r_word;
    logic        r_last;

    // The register may be loaded when empty or when its item leaves now.
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_req.valid) begin
            r_word <= encode_byte(i_req.data);
            r_last <= i_req.last;
        end
    end

    assign o_valid     = r_valid;
    assign o_line_word = r_word;
    assign o_last_word = r_last;

endmodule

>>> hdl/rgbfb_checker.sv
// Port-level checks for the RGB LED frame buffer encoder, bound to the top
// level. Depends on rgbfb_pkg and the top level's ports.
module rgbfb_port_checks (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [2:0]  i_req_type,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_line_word,
    input logic        o_last_word
);
    import rgbfb_pkg::*;

    // A waiting line item stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("line item withdrawn while stalled");

    // A stalled line item keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_line_word) && $stable(o_last_word))
        else $error("line payload changed while stalled");

    // An update or clear-all keeps the request side closed while it runs.
    a_update_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready &&
        (i_req_type == REQ_CLEAR_ALL || i_req_type == REQ_UPDATE)
        |=> !o_in_ready)
        else $error("request taken during an update");

    // Store writes and clears do not hold the request side closed.
    a_write_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_req_type == REQ_COLOR ||
        i_req_type == REQ_HUE || i_req_type == REQ_CLEAR_PIXEL) |=> o_in_ready)
        else $error("store write held the request side");

    // Every line word lies on the SPI bit pattern.
    a_word_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_line_word & 32'hDDDD_DDDD) == 32'h4444_4444))
        else $error("malformed line word");

endmodule

bind rgb_led_frame_buffer_encoder rgbfb_port_checks u_rgbfb_port_checks (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_req_type  (i_req_type),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_line_word (o_line_word),
    .o_last_word (o_last_word)
);

>>> test/rgbfb_checker.sv
// Checker for the RGB LED frame buffer encoder: watches the request, line and
// configuration channels, keeps a shadow pixel store and compares every line word.
// Depends on rgbfb_pkg.
module rgbfb_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [2:0]  i_req_type,
    input  logic [3:0]  i_pixel,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic [7:0]  i_hue,
    input  logic [1:0]  i_bright,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_line_word,
    input  logic        i_last_word,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic        i_cfg_data,
    output int          o_mismatches,
    output int          o_words_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    import rgbfb_pkg::*;

    localparam int STORE_BYTES = 3 * PIXELS;

    typedef struct packed {
        logic [31:0] code;
        logic        last;
    } t_line_item;

    logic [7:0] shadow_store [STORE_BYTES];
    logic       rgb_order;
    t_line_item owed_words [$];

    // Each bit pair of a byte, most significant first, becomes one SPI byte.
    function automatic logic [31:0] line_code(input logic [7:0] data);
        logic [31:0] word;
        logic [7:0]  bits;
        word = '0;
        bits = data;
        for (int k = 0; k < 4; k++) begin
            word = {word[23:0], (bits[7] ? 8'h60 : 8'h40) | (bits[6] ? 8'h06 : 8'h04)};
            bits = bits << 2;
        end
        return word;
    endfunction

    function automatic void store_pixel(input logic [3:0] px, input logic [7:0] r,
                                        input logic [7:0] g, input logic [7:0] b);
        int base;
        if (int'(px) >= PIXELS) begin
            return;
        end
        base = 3 * int'(px);
        shadow_store[base]     = rgb_order ? r : g;
        shadow_store[base + 1] = rgb_order ? g : r;
        shadow_store[base + 2] = b;
    endfunction

    function automatic void store_hue(input logic [3:0] px, input logic [7:0] hue,
                                      input logic [1:0] bright);
        logic [1:0] shift;
        logic [9:0] rise_w;
        logic [9:0] fall_w;
        logic [7:0] rise;
        logic [7:0] fall;
        shift  = (bright > BRIGHT_MAX) ? BRIGHT_MAX : bright;
        rise_w = {4'b0, hue[5:0]} << shift;
        rise   = rise_w[7:0];
        fall_w = ({2'b0, WHEEL_STEP_MAX} << shift) - {2'b0, rise};
        fall   = fall_w[7:0];
        case (hue[7:6])
            2'd0:         store_pixel(px, fall, rise, 8'h00);
            2'd1:         store_pixel(px, 8'h00, fall, rise);
            2'd2:         store_pixel(px, rise, 8'h00, fall);
            PHASE_UNUSED: ;
            default:      ;
        endcase
    endfunction

    function automatic void queue_frame();
        for (int i = 0; i < STORE_BYTES; i++) begin
            owed_words.push_back('{code: line_code(shadow_store[i]),
                                   last: (i == STORE_BYTES - 1)});
        end
    endfunction

    function automatic void predict_request();
        case (t_req'(i_req_type))
            REQ_COLOR:       store_pixel(i_pixel, i_red, i_green, i_blue);
            REQ_HUE:         store_hue(i_pixel, i_hue, i_bright);
            REQ_CLEAR_PIXEL: store_pixel(i_pixel, 8'h00, 8'h00, 8'h00);
            REQ_CLEAR_ALL: begin
                foreach (shadow_store[i]) shadow_store[i] = 8'h00;
                queue_frame();
            end
            REQ_UPDATE:      queue_frame();
            default:         ;
        endcase
    endfunction

    always @(posedge i_clk) begin : monitor
        t_line_item want;
        if (!i_rst_n) begin
            foreach (shadow_store[i]) shadow_store[i] = 8'h00;
            rgb_order = 1'b0;
            owed_words.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                rgb_order = i_cfg_data;
            end
            if (i_out_valid && i_out_ready) begin
                if (owed_words.size() == 0) begin
                    $error("line word %h arrived with nothing owed", i_line_word);
                    o_mismatches++;
                end else begin
                    want = owed_words.pop_front();
                    if (i_line_word !== want.code) begin
                        $error("line_word: expected %h, actual %h", want.code, i_line_word);
                        o_mismatches++;
                    end
                    if (i_last_word !== want.last) begin
                        $error("last_word: expected %b, actual %b", want.last, i_last_word);
                        o_mismatches++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_request();
            end
        end
        o_words_owed = owed_words.size();
    end

endmodule

>>> test/tb_rgb_led_frame_buffer_encoder.sv
// Testbench top for the RGB LED frame buffer encoder: clock, reset, request and
// configuration stimulus, line back-pressure, watchdog and verdict.
// Depends on rgbfb_pkg, rgbfb_checker and the block itself.
module tb_rgb_led_frame_buffer_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    import rgbfb_pkg::*;

    // Request codes above the last defined one are ignored by the block.
    localparam logic [2:0] REQ_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] REQ_MID_UNUSED   = 3'd6;
    localparam logic [2:0] REQ_LAST_UNUSED  = 3'd7;
    // Cycles the encoder may still be busy on a store write after the
    // last line word, and the slack left at the very end.
    localparam int SETTLE_CYCLES = 8;
    // Cycles without any accepted item before the run is declared hung.
    localparam int STALL_LIMIT = 2000;
    localparam int IDLE_PERCENT = 16;
    localparam int RANDOM_PHASES = 4;
    localparam int PHASE_ITEMS = 24;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [2:0]  i_req_type;
    logic [3:0]  i_pixel;
    logic [7:0]  i_red;
    logic [7:0]  i_green;
    logic [7:0]  i_blue;
    logic [7:0]  i_hue;
    logic [1:0]  i_bright;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [31:0] o_line_word;
    logic        o_last_word;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_data;

    int mismatches;
    int words_owed;
    int quiet_cycles;
    // While set, neither the request sender nor the line receiver idles.
    logic calm;

    rgb_led_frame_buffer_encoder DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .i_pixel     (i_pixel),
        .i_red       (i_red),
        .i_green     (i_green),
        .i_blue      (i_blue),
        .i_hue       (i_hue),
        .i_bright    (i_bright),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_line_word (o_line_word),
        .o_last_word (o_last_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    rgbfb_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_req_type   (i_req_type),
        .i_pixel      (i_pixel),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .i_hue        (i_hue),
        .i_bright     (i_bright),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_line_word  (o_line_word),
        .i_last_word  (o_last_word),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatches),
        .o_words_owed (words_owed)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #2 i_clk = ~i_clk;
        end
    end

    // The line receiver stalls in about IDLE_PERCENT percent of cycles, except while calm.
    // Its ready changes only at the falling edge, like every other input.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_ready = calm || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // The watchdog counts cycles in which no channel accepts an item. A
    // healthy run never goes long without one, since even a paused sender
    // leaves line words flowing and the pauses themselves are short.
    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Presents one request item and holds it until the block takes it. The
    // sender may idle first for a random number of cycles; valid stays high
    // from one item to the next when no idle cycle falls between them.
    task automatic send_request(input logic [2:0] req, input logic [3:0] px,
                                input logic [7:0] r, input logic [7:0] g,
                                input logic [7:0] b, input logic [7:0] hue,
                                input logic [1:0] bright);
        while (!calm && ($urandom_range(99) < IDLE_PERCENT)) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_req_type = req;
        i_pixel    = px;
        i_red      = r;
        i_green    = g;
        i_blue     = b;
        i_hue      = hue;
        i_bright   = bright;
        i_in_valid = 1'b1;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // Stops the sender and waits until every owed line word has come out,
    // then gives the block a few cycles to finish any write still in hand.
    task automatic settle();
        i_in_valid = 1'b0;
        while (words_owed != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // The colour order is changed only while the block is idle.
    task automatic write_order(input logic rgb);
        settle();
        i_cfg_data  = rgb;
        i_cfg_valid = 1'b1;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Random items are mostly well-formed pixel writes with frequent updates,
    // so that the store fills with varied content before each frame goes
    // out. Unused fields carry random values too, and some hue writes fall
    // into the ignored top quarter of the wheel.
    task automatic random_request();
        int         pick;
        logic [2:0] req;
        pick = $urandom_range(99);
        if (pick < 40) begin
            req = REQ_COLOR;
        end else if (pick < 75) begin
            req = REQ_HUE;
        end else if (pick < 83) begin
            req = REQ_CLEAR_PIXEL;
        end else if (pick < 88) begin
            req = 3'($urandom_range(REQ_FIRST_UNUSED, REQ_LAST_UNUSED));
        end else if (pick < 97) begin
            req = REQ_UPDATE;
        end else begin
            req = REQ_CLEAR_ALL;
        end
        send_request(req, 4'($urandom_range(PIXELS - 1)), 8'($urandom), 8'($urandom),
                     8'($urandom), 8'($urandom_range(255)), 2'($urandom_range(3)));
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_req_type  = REQ_COLOR;
        i_pixel     = '0;
        i_red       = '0;
        i_green     = '0;
        i_blue      = '0;
        i_hue       = '0;
        i_bright    = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = 1'b0;
        calm        = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, green-red-blue order. A frame straight after reset
        // must be all zero bytes.
        write_order(1'b0);
        send_request(REQ_UPDATE, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00, 2'd0);
        // Extreme colour values at both ends of the chain and in the middle.
        send_request(REQ_COLOR, 4'd0, 8'hFF, 8'h00, 8'hAA, 8'h00, 2'd0);
        send_request(REQ_COLOR, 4'd15, 8'h00, 8'hFF, 8'h55, 8'hFF, 2'd3);
        send_request(REQ_COLOR, 4'd7, 8'hFF, 8'hFF, 8'hFF, 8'h00, 2'd0);
        // The colour wheel at the start and end of each phase, with every
        // brightness, including the clamped one.
        send_request(REQ_HUE, 4'd1, 8'h00, 8'h00, 8'h00, 8'd0, 2'd0);
        send_request(REQ_HUE, 4'd2, 8'h00, 8'h00, 8'h00, 8'd63, 2'd1);
        send_request(REQ_HUE, 4'd3, 8'h00, 8'h00, 8'h00, 8'd64, 2'd2);
        send_request(REQ_HUE, 4'd4, 8'h00, 8'h00, 8'h00, 8'd127, 2'd3);
        send_request(REQ_HUE, 4'd5, 8'h00, 8'h00, 8'h00, 8'd128, 2'd0);
        send_request(REQ_HUE, 4'd6, 8'h00, 8'h00, 8'h00, 8'd191, 2'd2);
        // Hues beyond the wheel must leave pixels 0 and 15 as they are.
        send_request(REQ_HUE, 4'd0, 8'h00, 8'h00, 8'h00, 8'd192, 2'd1);
        send_request(REQ_HUE, 4'd15, 8'h00, 8'h00, 8'h00, 8'd255, 2'd3);
        send_request(REQ_CLEAR_PIXEL, 4'd7, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 2'd3);
        // Unknown request codes are ignored and give no line words.
        send_request(REQ_FIRST_UNUSED, 4'd8, 8'hFF, 8'hFF, 8'hFF, 8'd10, 2'd1);
        send_request(REQ_MID_UNUSED, 4'd9, 8'hFF, 8'hFF, 8'hFF, 8'd20, 2'd2);
        send_request(REQ_LAST_UNUSED, 4'd10, 8'hFF, 8'hFF, 8'hFF, 8'd30, 2'd0);
        send_request(REQ_UPDATE, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00, 2'd0);

        // Red-green-blue order, then a clear-all that must drop everything.
        write_order(1'b1);
        send_request(REQ_COLOR, 4'd3, 8'h12, 8'h34, 8'h56, 8'h00, 2'd0);
        send_request(REQ_HUE, 4'd4, 8'h00, 8'h00, 8'h00, 8'd100, 2'd3);
        send_request(REQ_UPDATE, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00, 2'd0);
        send_request(REQ_CLEAR_ALL, 4'd15, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 2'd3);

        // Random part. Each phase starts from an idle block, the colour order alternating
        // from phase to phase; the second phase runs with no idling on either side.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            write_order(phase[0] ^ 1'b1);
            calm = (phase == 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                random_request();
            end
            send_request(REQ_UPDATE, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00, 2'd0);
        end
        calm = 1'b0;

        settle();
        if (mismatches == 0 && words_owed == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/rgbfb_pkg.sv
hdl/rgbfb_line_out.sv
hdl/rgb_led_frame_buffer_encoder.sv
hdl/rgbfb_checker.sv
test/rgbfb_checker.sv
test/tb_rgb_led_frame_buffer_encoder.sv
